### design/adsr_pkg.sv
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared widths, codes and controller/datapath interface types for the
// exponential ADSR envelope amplifier.
// ----------------------------------------------------------------------------
package adsr_pkg;

    // Field and register widths
    localparam int SMP_W  = 24;   // audio sample
    localparam int ENV_W  = 25;   // envelope level, 1.0 = 2^24
    localparam int COEF_W = 24;   // feedback coefficient, Q0.24
    localparam int BASE_W = 26;   // additive base, signed Q2.24
    localparam int FRAC_W = 24;   // fractional bits of the envelope
    localparam int CFG_W  = 26;   // widest configuration register
    localparam int IDX_W  = 3;    // configuration register index
    localparam int MODE_W = 2;

    localparam logic [ENV_W-1:0] ONE_Q24 = ENV_W'(1) << FRAC_W;

    // Item kinds
    typedef enum logic [MODE_W-1:0] {
        MODE_TICK     = 2'd0,
        MODE_NOTE_ON  = 2'd1,
        MODE_NOTE_OFF = 2'd2,
        MODE_RESET    = 2'd3
    } t_mode;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_ATTACK_COEFF  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_ATTACK_BASE   = 3'd1;
    localparam logic [IDX_W-1:0] CFG_DECAY_COEFF   = 3'd2;
    localparam logic [IDX_W-1:0] CFG_DECAY_BASE    = 3'd3;
    localparam logic [IDX_W-1:0] CFG_RELEASE_COEFF = 3'd4;
    localparam logic [IDX_W-1:0] CFG_RELEASE_BASE  = 3'd5;
    localparam logic [IDX_W-1:0] CFG_SUSTAIN_LEVEL = 3'd6;

    // Envelope segment the datapath advances on a tick
    typedef enum logic [1:0] {
        SEG_HOLD,
        SEG_ATTACK,
        SEG_DECAY,
        SEG_RELEASE
    } t_seg;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;    // capture the tick's sample
        logic clr_level;  // force the envelope to zero
        logic mul_env;    // level * coeff
        logic upd_level;  // add base, clamp, write level
        logic mul_out;    // sample * level
        logic load_out;   // move result into the output register
        t_seg seg;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic seg_end;    // the segment reached its clamp on this update
    } t_dp_sts;

endpackage

### design/adsr_dp.sv
// ----------------------------------------------------------------------------
// adsr_dp
// Datapath: configuration registers, envelope level, the level*coeff
// multiply with base add and clamp, and the sample*level output multiply.
// ----------------------------------------------------------------------------
module adsr_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [adsr_pkg::IDX_W-1:0]          i_cfg_index,
    input  logic [adsr_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic signed [adsr_pkg::SMP_W-1:0]   i_sample_in,
    input  adsr_pkg::t_dp_cmd                   i_cmd,
    output adsr_pkg::t_dp_sts                   o_sts,
    output logic signed [adsr_pkg::SMP_W-1:0]   o_sample_out,
    output logic [adsr_pkg::ENV_W-1:0]          o_envelope
);

    localparam int SUM_W  = adsr_pkg::BASE_W + 1;
    localparam int PENV_W = adsr_pkg::ENV_W + adsr_pkg::COEF_W;
    localparam int POUT_W = adsr_pkg::SMP_W + adsr_pkg::ENV_W + 1;
    localparam logic signed [SUM_W-1:0] ONE_S =
        $signed({{(SUM_W-adsr_pkg::ENV_W){1'b0}}, adsr_pkg::ONE_Q24});

    // Configuration registers
    logic [adsr_pkg::COEF_W-1:0]        r_attack_coeff, r_decay_coeff, r_release_coeff;
    logic signed [adsr_pkg::BASE_W-1:0] r_attack_base, r_decay_base, r_release_base;
    logic [adsr_pkg::ENV_W-1:0]         r_sustain;

    // Working registers
    logic [adsr_pkg::ENV_W-1:0]         r_level, n_level;
    logic signed [adsr_pkg::SMP_W-1:0]  r_sample;
    logic [adsr_pkg::ENV_W-1:0]         r_env_q;
    logic signed [POUT_W-1:0]           r_prod_out;
    logic signed [adsr_pkg::SMP_W-1:0]  r_sample_out;
    logic [adsr_pkg::ENV_W-1:0]         r_envelope;

    logic [adsr_pkg::COEF_W-1:0]        w_coeff;
    logic signed [adsr_pkg::BASE_W-1:0] w_base;
    logic [PENV_W-1:0]                  w_prod_env;
    logic signed [SUM_W-1:0]            w_sum;
    logic [adsr_pkg::ENV_W-1:0]         w_sus;
    logic signed [SUM_W-1:0]            w_sus_s;
    logic [adsr_pkg::ENV_W-1:0]         w_sum_sat;
    logic signed [adsr_pkg::ENV_W:0]    w_level_s;
    logic                               w_seg_end;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack_coeff  <= '0;
            r_attack_base   <= '0;
            r_decay_coeff   <= '0;
            r_decay_base    <= '0;
            r_release_coeff <= '0;
            r_release_base  <= '0;
            r_sustain       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                adsr_pkg::CFG_ATTACK_COEFF:  r_attack_coeff  <= i_cfg_data[adsr_pkg::COEF_W-1:0];
                adsr_pkg::CFG_ATTACK_BASE:   r_attack_base   <= $signed(i_cfg_data[adsr_pkg::BASE_W-1:0]);
                adsr_pkg::CFG_DECAY_COEFF:   r_decay_coeff   <= i_cfg_data[adsr_pkg::COEF_W-1:0];
                adsr_pkg::CFG_DECAY_BASE:    r_decay_base    <= $signed(i_cfg_data[adsr_pkg::BASE_W-1:0]);
                adsr_pkg::CFG_RELEASE_COEFF: r_release_coeff <= i_cfg_data[adsr_pkg::COEF_W-1:0];
                adsr_pkg::CFG_RELEASE_BASE:  r_release_base  <= $signed(i_cfg_data[adsr_pkg::BASE_W-1:0]);
                adsr_pkg::CFG_SUSTAIN_LEVEL: r_sustain       <= i_cfg_data[adsr_pkg::ENV_W-1:0];
                default: ;
            endcase
        end
    end

    // Select coefficient and base for the active segment
    always_comb begin
        case (i_cmd.seg)
            adsr_pkg::SEG_ATTACK:  begin w_coeff = r_attack_coeff;  w_base = r_attack_base;  end
            adsr_pkg::SEG_DECAY:   begin w_coeff = r_decay_coeff;   w_base = r_decay_base;   end
            adsr_pkg::SEG_RELEASE: begin w_coeff = r_release_coeff; w_base = r_release_base; end
            default:               begin w_coeff = '0;              w_base = '0;             end
        endcase
    end

    assign w_prod_env = PENV_W'(r_level) * PENV_W'(w_coeff);

    // Base plus scaled level, and the clamp targets
    assign w_sum     = SUM_W'(w_base) + $signed({{(SUM_W-adsr_pkg::ENV_W){1'b0}}, r_env_q});
    assign w_sus     = (r_sustain > adsr_pkg::ONE_Q24) ? adsr_pkg::ONE_Q24 : r_sustain;
    assign w_sus_s   = $signed({{(SUM_W-adsr_pkg::ENV_W){1'b0}}, w_sus});
    assign w_sum_sat = (w_sum > ONE_S) ? adsr_pkg::ONE_Q24 : w_sum[adsr_pkg::ENV_W-1:0];

    // Clamp per segment and flag the end of the segment
    always_comb begin
        n_level   = r_level;
        w_seg_end = 1'b0;
        case (i_cmd.seg)
            adsr_pkg::SEG_ATTACK: begin
                if (w_sum >= ONE_S) begin
                    n_level   = adsr_pkg::ONE_Q24;
                    w_seg_end = 1'b1;
                end else if (w_sum < 0) begin
                    n_level = '0;
                end else begin
                    n_level = w_sum[adsr_pkg::ENV_W-1:0];
                end
            end
            adsr_pkg::SEG_DECAY: begin
                if (w_sum <= w_sus_s) begin
                    n_level   = w_sus;
                    w_seg_end = 1'b1;
                end else begin
                    n_level = w_sum_sat;
                end
            end
            adsr_pkg::SEG_RELEASE: begin
                if (w_sum <= 0) begin
                    n_level   = '0;
                    w_seg_end = 1'b1;
                end else begin
                    n_level = w_sum_sat;
                end
            end
            default: ;
        endcase
    end

    assign o_sts.seg_end = w_seg_end;
    assign w_level_s     = $signed({1'b0, r_level});

    // Envelope state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (i_cmd.clr_level) begin
            r_level <= '0;
        end else if (i_cmd.upd_level) begin
            r_level <= n_level;
        end
    end

    // Arithmetic pipeline registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_sample <= i_sample_in;
        end
        if (i_cmd.mul_env) begin
            r_env_q <= w_prod_env[adsr_pkg::FRAC_W +: adsr_pkg::ENV_W];
        end
        if (i_cmd.mul_out) begin
            r_prod_out <= r_sample * w_level_s;
        end
        if (i_cmd.load_out) begin
            r_sample_out <= r_prod_out[adsr_pkg::FRAC_W +: adsr_pkg::SMP_W];
            r_envelope   <= r_level;
        end
    end

    assign o_sample_out = r_sample_out;
    assign o_envelope   = r_envelope;

endmodule

### design/adsr_ctrl.sv
// ----------------------------------------------------------------------------
// adsr_ctrl
// Controller: input/output handshake, envelope phase and the sequence of
// datapath steps for one sample tick.
// ----------------------------------------------------------------------------
module adsr_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [adsr_pkg::MODE_W-1:0]   i_mode,
    output logic                          o_in_ready,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output adsr_pkg::t_dp_cmd             o_cmd,
    input  adsr_pkg::t_dp_sts             i_sts
);

    typedef enum logic [2:0] {
        ST_WAIT,
        ST_MUL_ENV,
        ST_UPDATE,
        ST_MUL_OUT,
        ST_LOAD
    } t_state;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ATTACK,
        PH_DECAY,
        PH_SUSTAIN,
        PH_RELEASE
    } t_phase;

    t_state r_state;
    t_phase r_phase;
    logic   r_out_valid;
    logic   w_accept;
    logic   w_out_free;

    assign o_in_ready  = (r_state == ST_WAIT);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    // Drive datapath commands
    always_comb begin
        o_cmd.load_in   = w_accept && (i_mode == adsr_pkg::MODE_TICK);
        o_cmd.clr_level = w_accept && (i_mode == adsr_pkg::MODE_RESET);
        o_cmd.mul_env   = (r_state == ST_MUL_ENV);
        o_cmd.upd_level = (r_state == ST_UPDATE);
        o_cmd.mul_out   = (r_state == ST_MUL_OUT);
        o_cmd.load_out  = (r_state == ST_LOAD) && w_out_free;
        unique case (r_phase)
            PH_ATTACK:  o_cmd.seg = adsr_pkg::SEG_ATTACK;
            PH_DECAY:   o_cmd.seg = adsr_pkg::SEG_DECAY;
            PH_RELEASE: o_cmd.seg = adsr_pkg::SEG_RELEASE;
            default:    o_cmd.seg = adsr_pkg::SEG_HOLD;
        endcase
    end

    // Sequence state, envelope phase and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_WAIT;
            r_phase     <= PH_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // raise valid as a result item is loaded, drop it once taken
            if ((r_state == ST_LOAD) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_WAIT: begin
                    if (w_accept) begin
                        unique case (i_mode)
                            adsr_pkg::MODE_TICK: begin
                                r_state <= ST_MUL_ENV;
                            end
                            adsr_pkg::MODE_NOTE_ON: begin
                                // legato: restart only from idle or release
                                if (r_phase == PH_IDLE || r_phase == PH_RELEASE) begin
                                    r_phase <= PH_ATTACK;
                                end
                            end
                            adsr_pkg::MODE_NOTE_OFF: begin
                                if (r_phase != PH_IDLE) begin
                                    r_phase <= PH_RELEASE;
                                end
                            end
                            default: begin
                                r_phase <= PH_IDLE;
                            end
                        endcase
                    end
                end
                ST_MUL_ENV: begin
                    r_state <= ST_UPDATE;
                end
                ST_UPDATE: begin
                    // advance the phase when the segment hits its clamp
                    if (i_sts.seg_end) begin
                        unique case (r_phase)
                            PH_ATTACK:  r_phase <= PH_DECAY;
                            PH_DECAY:   r_phase <= PH_SUSTAIN;
                            PH_RELEASE: r_phase <= PH_IDLE;
                            default:    r_phase <= r_phase;
                        endcase
                    end
                    r_state <= ST_MUL_OUT;
                end
                ST_MUL_OUT: begin
                    r_state <= ST_LOAD;
                end
                ST_LOAD: begin
                    // hold until the output register is free
                    if (w_out_free) begin
                        r_state <= ST_WAIT;
                    end
                end
                default: begin
                    r_state <= ST_WAIT;
                end
            endcase
        end
    end

endmodule

### design/adsr_envelope_amp_core.sv
// ----------------------------------------------------------------------------
// adsr_envelope_amp_core
// Exponential ADSR amplitude envelope applied to a 24-bit audio stream.
// ----------------------------------------------------------------------------
// Each input item is a sample tick, note-on, note-off or reset (i_mode). A
// tick advances the envelope (level = base + level*coeff, clamped per phase)
// and returns one result item: the sample scaled by the new envelope and the
// envelope itself (1.0 = 2^24). Other items return nothing and leave the
// block ready for the next item. A tick holds o_in_ready low while it runs
// through one multiply of level by coefficient, one base add and clamp, one
// multiply of sample by level, and the load of the output register. Its
// result item is valid once that load is done. The load waits while the
// output register still holds an untaken result, stretching the tick by the
// stall; the output register lets the next item be taken while a finished
// result waits. The user must write coefficients, bases and sustain level
// through the configuration port only while no item is in progress; the
// block itself does not enforce this. Registers reset to zero and the reset
// item leaves them unchanged.
module adsr_envelope_amp_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [adsr_pkg::IDX_W-1:0]          i_cfg_index,
    input  logic [adsr_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [adsr_pkg::MODE_W-1:0]         i_mode,
    input  logic signed [adsr_pkg::SMP_W-1:0]   i_sample_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [adsr_pkg::SMP_W-1:0]   o_sample_out,
    output logic [adsr_pkg::ENV_W-1:0]          o_envelope
);

    adsr_pkg::t_dp_cmd w_cmd;
    adsr_pkg::t_dp_sts w_sts;

    // Sequence and phase control
    adsr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_mode      (i_mode),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // Arithmetic and registers
    adsr_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_sample_in  (i_sample_in),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_sample_out (o_sample_out),
        .o_envelope   (o_envelope)
    );

    // Envelope never exceeds one
    a_env_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_envelope <= adsr_pkg::ONE_Q24))
        else $error("envelope above one");

    // A tick blocks further items while it is worked on
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_mode == adsr_pkg::MODE_TICK) |=> !o_in_ready)
        else $error("item accepted during a tick");

    // Only ticks produce result items
    a_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_mode != adsr_pkg::MODE_TICK)
            |=> !$rose(o_out_valid))
        else $error("result from a non-tick item");

    // A non-tick item keeps the block ready
    a_cmd_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_mode != adsr_pkg::MODE_TICK) |=> o_in_ready)
        else $error("block stalled after a command item");

endmodule

### sim/tb_adsr_envelope_amp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adsr_envelope_amp_core
// Self-checking bench for the exponential ADSR envelope amplifier. A
// scoreboard class tracks envelope phase and level from the stimulus and
// predicts each tick's scaled sample and envelope. Stimulus is a directed
// note walk, then random note phrases with noise under several register
// profiles. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------

localparam longint UNITY_Q24 = longint'(adsr_pkg::ONE_Q24);

typedef enum logic [2:0] {
    PH_IDLE,
    PH_ATTACK,
    PH_DECAY,
    PH_SUSTAIN,
    PH_RELEASE
} t_env_phase;

typedef struct {
    adsr_pkg::t_mode                     mode;
    logic signed [adsr_pkg::SMP_W-1:0]   smp;
} t_stim_item;

typedef struct {
    logic signed [adsr_pkg::SMP_W-1:0]   smp_out;
    logic [adsr_pkg::ENV_W-1:0]          env;
} t_env_result;

class envelope_scoreboard;
    longint         atk_coeff, atk_base, dec_coeff, dec_base;
    longint         rel_coeff, rel_base, sus_level;
    t_env_phase     env_phase;
    longint         env_level;
    t_env_result    expected_q[$];
    int             mismatches;
    int             results_seen;

    function new();
        atk_coeff = 0; atk_base = 0; dec_coeff = 0; dec_base = 0;
        rel_coeff = 0; rel_base = 0; sus_level = 0;
        env_phase = PH_IDLE;
        env_level = 0;
        mismatches = 0;
        results_seen = 0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // Mirror a register write
    function void write_reg(logic [adsr_pkg::IDX_W-1:0] idx,
                            logic [adsr_pkg::CFG_W-1:0] data);
        case (idx)
            adsr_pkg::CFG_ATTACK_COEFF:
                atk_coeff = longint'(data[adsr_pkg::COEF_W-1:0]);
            adsr_pkg::CFG_ATTACK_BASE:
                atk_base  = longint'($signed(data[adsr_pkg::BASE_W-1:0]));
            adsr_pkg::CFG_DECAY_COEFF:
                dec_coeff = longint'(data[adsr_pkg::COEF_W-1:0]);
            adsr_pkg::CFG_DECAY_BASE:
                dec_base  = longint'($signed(data[adsr_pkg::BASE_W-1:0]));
            adsr_pkg::CFG_RELEASE_COEFF:
                rel_coeff = longint'(data[adsr_pkg::COEF_W-1:0]);
            adsr_pkg::CFG_RELEASE_BASE:
                rel_base  = longint'($signed(data[adsr_pkg::BASE_W-1:0]));
            adsr_pkg::CFG_SUSTAIN_LEVEL:
                sus_level = longint'(data[adsr_pkg::ENV_W-1:0]);
            default: ;
        endcase
    endfunction

    function longint clamp_one(longint v);
        return (v > UNITY_Q24) ? UNITY_Q24 : v;
    endfunction

    function longint next_level(longint base, longint coeff);
        return base + ((env_level * coeff) >>> adsr_pkg::FRAC_W);
    endfunction

    // Advance phase and level for one accepted item; queue a result on ticks
    function void note_item(adsr_pkg::t_mode mode, logic signed [adsr_pkg::SMP_W-1:0] smp);
        longint      sus;
        longint      nv;
        longint      prod;
        t_env_result r;
        case (mode)
            adsr_pkg::MODE_NOTE_ON: begin
                if (env_phase == PH_IDLE || env_phase == PH_RELEASE) begin
                    env_phase = PH_ATTACK;
                end
            end
            adsr_pkg::MODE_NOTE_OFF: begin
                if (env_phase != PH_IDLE) begin
                    env_phase = PH_RELEASE;
                end
            end
            adsr_pkg::MODE_RESET: begin
                env_phase = PH_IDLE;
                env_level = 0;
            end
            default: begin
                sus = clamp_one(sus_level);
                case (env_phase)
                    PH_ATTACK: begin
                        nv = next_level(atk_base, atk_coeff);
                        if (nv >= UNITY_Q24) begin
                            nv = UNITY_Q24;
                            env_phase = PH_DECAY;
                        end else if (nv < 0) begin
                            nv = 0;
                        end
                        env_level = nv;
                    end
                    PH_DECAY: begin
                        nv = next_level(dec_base, dec_coeff);
                        if (nv <= sus) begin
                            nv = sus;
                            env_phase = PH_SUSTAIN;
                        end
                        env_level = clamp_one(nv);
                    end
                    PH_RELEASE: begin
                        nv = next_level(rel_base, rel_coeff);
                        if (nv <= 0) begin
                            nv = 0;
                            env_phase = PH_IDLE;
                        end
                        env_level = clamp_one(nv);
                    end
                    default: ;
                endcase
                // floor of sample * level / 2^24
                prod = longint'(smp) * env_level;
                r.smp_out = adsr_pkg::SMP_W'(prod >>> adsr_pkg::FRAC_W);
                r.env     = adsr_pkg::ENV_W'(env_level);
                expected_q.push_back(r);
            end
        endcase
    endfunction

    function void report_mismatch(string what, logic signed [31:0] expv,
                                  logic signed [31:0] actv);
        mismatches++;
        $display("%0t: %s mismatch: expected %0d, actual %0d",
                 $time, what, expv, actv);
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_result(logic signed [adsr_pkg::SMP_W-1:0] smp_out,
                               logic [adsr_pkg::ENV_W-1:0] env);
        t_env_result exp_r;
        results_seen++;
        if (expected_q.size() == 0) begin
            mismatches++;
            $display("%0t: result with no item waiting: sample_out %0d envelope %0d",
                     $time, smp_out, env);
            return;
        end
        exp_r = expected_q.pop_front();
        if (smp_out !== exp_r.smp_out) begin
            report_mismatch("sample_out", exp_r.smp_out, smp_out);
        end
        if (env !== exp_r.env) begin
            report_mismatch("envelope", exp_r.env, env);
        end
    endfunction
endclass

module tb_adsr_envelope_amp_core;

    localparam int PROF_SHAPED       = 0;
    localparam int PROF_LOW_EXTREME  = 1;
    localparam int PROF_HIGH_EXTREME = 2;
    localparam int PROF_RANDOM       = 3;
    localparam int PROF_MIXED        = 4;
    localparam int PROF_LOUD_SUSTAIN = 5;

    localparam int NUM_PHASES = 8;
    localparam int PHASE_PLAN [NUM_PHASES] = '{PROF_SHAPED, PROF_LOW_EXTREME,
        PROF_SHAPED, PROF_HIGH_EXTREME, PROF_RANDOM, PROF_LOUD_SUSTAIN,
        PROF_MIXED, PROF_SHAPED};
    localparam int ITEMS_PER_PHASE = 180;

    localparam int CFG_W  = adsr_pkg::CFG_W;
    localparam int SMP_W  = adsr_pkg::SMP_W;
    localparam int IDX_W  = adsr_pkg::IDX_W;

    localparam logic [CFG_W-1:0] COEF_MAX = CFG_W'(24'hFFFFFF);
    localparam logic [CFG_W-1:0] BASE_MIN = {1'b1, {(CFG_W-1){1'b0}}};
    localparam logic [CFG_W-1:0] BASE_MAX = {1'b0, {(CFG_W-1){1'b1}}};
    localparam logic [CFG_W-1:0] SUS_MAX  = CFG_W'(25'h1FFFFFF);

    logic                                i_clk = 1'b0;
    logic                                i_rst_n;
    logic                                i_cfg_we;
    logic [IDX_W-1:0]                    i_cfg_index;
    logic [CFG_W-1:0]                    i_cfg_data;
    logic                                i_in_valid;
    logic                                o_in_ready;
    logic [adsr_pkg::MODE_W-1:0]         i_mode;
    logic signed [SMP_W-1:0]             i_sample_in;
    logic                                o_out_valid;
    logic                                i_out_ready;
    logic signed [SMP_W-1:0]             o_sample_out;
    logic [adsr_pkg::ENV_W-1:0]          o_envelope;

    envelope_scoreboard sb = new();
    t_stim_item         stim_q[$];
    logic [CFG_W-1:0]   reg_plan [7];

    adsr_envelope_amp_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out),
        .o_envelope   (o_envelope)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial begin
        #4_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic logic signed [SMP_W-1:0] pick_sample();
        case ($urandom_range(0, 11))
            0:       return {1'b1, {(SMP_W-1){1'b0}}};
            1:       return {1'b0, {(SMP_W-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            default: return SMP_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_extreme(logic [CFG_W-1:0] lo,
                                                      logic [CFG_W-1:0] hi,
                                                      logic [CFG_W-1:0] rnd);
        case ($urandom_range(0, 2))
            0:       return lo;
            1:       return hi;
            default: return rnd;
        endcase
    endfunction

    function automatic void push_item(adsr_pkg::t_mode mode, logic signed [SMP_W-1:0] smp);
        t_stim_item it;
        it.mode = mode;
        it.smp  = smp;
        stim_q.push_back(it);
    endfunction

    // Build a register set; shaped profiles give envelopes that finish segments
    function automatic void fill_profile(int prof);
        longint c;
        longint t;
        longint sus;
        longint d;
        case (prof)
            PROF_SHAPED, PROF_LOUD_SUSTAIN: begin
                c = longint'($urandom_range(10066330, 15938355));
                t = longint'($urandom_range(21810381, 50331648));
                reg_plan[adsr_pkg::CFG_ATTACK_COEFF] = CFG_W'(c);
                reg_plan[adsr_pkg::CFG_ATTACK_BASE]  =
                    CFG_W'(((UNITY_Q24 - c) * t) >>> adsr_pkg::FRAC_W);
                if (prof == PROF_LOUD_SUSTAIN) begin
                    sus = longint'($urandom_range(16777217, 33554431));
                end else begin
                    sus = longint'($urandom_range(0, 16777216));
                end
                reg_plan[adsr_pkg::CFG_SUSTAIN_LEVEL] = CFG_W'(sus);
                if (sus > UNITY_Q24) begin
                    sus = UNITY_Q24;
                end
                c = longint'($urandom_range(10066330, 15938355));
                d = longint'($urandom_range(838861, 5033165));
                reg_plan[adsr_pkg::CFG_DECAY_COEFF] = CFG_W'(c);
                reg_plan[adsr_pkg::CFG_DECAY_BASE]  =
                    CFG_W'(((UNITY_Q24 - c) * (sus - d)) >>> adsr_pkg::FRAC_W);
                c = longint'($urandom_range(10066330, 15938355));
                d = longint'($urandom_range(1678, 5033165));
                reg_plan[adsr_pkg::CFG_RELEASE_COEFF] = CFG_W'(c);
                reg_plan[adsr_pkg::CFG_RELEASE_BASE]  =
                    CFG_W'(-(((UNITY_Q24 - c) * d) >>> adsr_pkg::FRAC_W));
            end
            PROF_LOW_EXTREME: begin
                reg_plan[adsr_pkg::CFG_ATTACK_COEFF]  = '0;
                reg_plan[adsr_pkg::CFG_ATTACK_BASE]   = BASE_MIN;
                reg_plan[adsr_pkg::CFG_DECAY_COEFF]   = '0;
                reg_plan[adsr_pkg::CFG_DECAY_BASE]    = BASE_MIN;
                reg_plan[adsr_pkg::CFG_RELEASE_COEFF] = '0;
                reg_plan[adsr_pkg::CFG_RELEASE_BASE]  = BASE_MIN;
                reg_plan[adsr_pkg::CFG_SUSTAIN_LEVEL] = '0;
            end
            PROF_HIGH_EXTREME: begin
                reg_plan[adsr_pkg::CFG_ATTACK_COEFF]  = COEF_MAX;
                reg_plan[adsr_pkg::CFG_ATTACK_BASE]   = BASE_MAX;
                reg_plan[adsr_pkg::CFG_DECAY_COEFF]   = COEF_MAX;
                reg_plan[adsr_pkg::CFG_DECAY_BASE]    = BASE_MAX;
                reg_plan[adsr_pkg::CFG_RELEASE_COEFF] = COEF_MAX;
                reg_plan[adsr_pkg::CFG_RELEASE_BASE]  = BASE_MAX;
                reg_plan[adsr_pkg::CFG_SUSTAIN_LEVEL] = SUS_MAX;
            end
            PROF_RANDOM: begin
                reg_plan[adsr_pkg::CFG_ATTACK_COEFF]  = CFG_W'($urandom) & COEF_MAX;
                reg_plan[adsr_pkg::CFG_ATTACK_BASE]   = CFG_W'($urandom);
                reg_plan[adsr_pkg::CFG_DECAY_COEFF]   = CFG_W'($urandom) & COEF_MAX;
                reg_plan[adsr_pkg::CFG_DECAY_BASE]    = CFG_W'($urandom);
                reg_plan[adsr_pkg::CFG_RELEASE_COEFF] = CFG_W'($urandom) & COEF_MAX;
                reg_plan[adsr_pkg::CFG_RELEASE_BASE]  = CFG_W'($urandom);
                reg_plan[adsr_pkg::CFG_SUSTAIN_LEVEL] = CFG_W'($urandom) & SUS_MAX;
            end
            default: begin
                reg_plan[adsr_pkg::CFG_ATTACK_COEFF]  =
                    pick_extreme('0, COEF_MAX, CFG_W'($urandom) & COEF_MAX);
                reg_plan[adsr_pkg::CFG_ATTACK_BASE]   =
                    pick_extreme(BASE_MIN, BASE_MAX, CFG_W'($urandom));
                reg_plan[adsr_pkg::CFG_DECAY_COEFF]   =
                    pick_extreme('0, COEF_MAX, CFG_W'($urandom) & COEF_MAX);
                reg_plan[adsr_pkg::CFG_DECAY_BASE]    =
                    pick_extreme(BASE_MIN, BASE_MAX, CFG_W'($urandom));
                reg_plan[adsr_pkg::CFG_RELEASE_COEFF] =
                    pick_extreme('0, COEF_MAX, CFG_W'($urandom) & COEF_MAX);
                reg_plan[adsr_pkg::CFG_RELEASE_BASE]  =
                    pick_extreme(BASE_MIN, BASE_MAX, CFG_W'($urandom));
                reg_plan[adsr_pkg::CFG_SUSTAIN_LEVEL] =
                    pick_extreme('0, CFG_W'(adsr_pkg::ONE_Q24), CFG_W'($urandom) & SUS_MAX);
            end
        endcase
    endfunction

    // Mostly whole notes with random content, some loose noise items
    function automatic void queue_note_phrases(int n);
        int target;
        target = stim_q.size() + n;
        while (stim_q.size() < target) begin
            if ($urandom_range(0, 99) < 85) begin
                if ($urandom_range(0, 9) == 0) begin
                    push_item(adsr_pkg::MODE_RESET, pick_sample());
                end
                push_item(adsr_pkg::MODE_NOTE_ON, pick_sample());
                repeat ($urandom_range(1, 48)) push_item(adsr_pkg::MODE_TICK, pick_sample());
                if ($urandom_range(0, 4) == 0) begin
                    push_item(adsr_pkg::MODE_NOTE_ON, pick_sample());
                    repeat ($urandom_range(1, 16))
                        push_item(adsr_pkg::MODE_TICK, pick_sample());
                end
                push_item(adsr_pkg::MODE_NOTE_OFF, pick_sample());
                repeat ($urandom_range(0, 40)) push_item(adsr_pkg::MODE_TICK, pick_sample());
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    push_item(adsr_pkg::t_mode'($urandom_range(0, 3)), pick_sample());
                end
            end
        end
    endfunction

    task automatic wait_for_results();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Drain outstanding results, then give non-tick items time to retire
    task automatic settle_block();
        wait_for_results();
        repeat (16) @(posedge i_clk);
    endtask

    task automatic program_regs();
        for (int i = 0; i < 7; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= IDX_W'(i);
            i_cfg_data  <= reg_plan[i];
            sb.write_reg(IDX_W'(i), reg_plan[i]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offer one item and hold it until accepted
    task automatic send_item(input t_stim_item it);
        i_in_valid  <= 1'b1;
        i_mode      <= it.mode;
        i_sample_in <= it.smp;
        @(negedge i_clk);
        while (!o_in_ready) @(negedge i_clk);
        sb.note_item(it.mode, it.smp);
        @(posedge i_clk);
    endtask

    // Send queued items in bursts; optionally pause once until drained
    task automatic drive_items(input int pause_at);
        t_stim_item it;
        int         burst;
        int         sent;
        sent = 0;
        while (stim_q.size() != 0) begin
            burst = $urandom_range(1, 24);
            while (burst != 0 && stim_q.size() != 0) begin
                it = stim_q.pop_front();
                send_item(it);
                sent++;
                burst--;
                if (sent == pause_at) begin
                    i_in_valid <= 1'b0;
                    @(posedge i_clk);
                    wait_for_results();
                end
            end
            if ($urandom_range(0, 3) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Result side: stall on a pattern that changes per window
    initial begin : result_sink
        int  window_left;
        int  style;
        int  cyc;
        int  hold_left;
        bit  long_done;
        bit  rdy;
        window_left = 0;
        style = 0;
        cyc = 0;
        hold_left = 0;
        long_done = 1'b0;
        i_out_ready = 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (window_left == 0) begin
                window_left = $urandom_range(16, 96);
                style = $urandom_range(0, 3);
            end
            window_left--;
            cyc++;
            case (style)
                0:       rdy = 1'b1;
                1:       rdy = 1'($urandom_range(0, 1));
                2:       rdy = (cyc % 4) == 0;
                default: rdy = $urandom_range(0, 4) == 0;
            endcase
            // hold off once for a long stretch so the input side backs up
            if (!long_done && sb.results_seen >= 300) begin
                long_done = 1'b1;
                hold_left = 600;
            end
            if (hold_left != 0) begin
                hold_left--;
                rdy = 1'b0;
            end
            i_out_ready <= rdy;
            @(negedge i_clk);
            if (o_out_valid && i_out_ready) begin
                sb.check_result(o_sample_out, o_envelope);
            end
            @(posedge i_clk);
        end
    end

    initial begin : stimulus_main
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_mode      = adsr_pkg::MODE_TICK;
        i_sample_in = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Registers at reset: tick in idle, then attack that cannot move
        push_item(adsr_pkg::MODE_TICK, {1'b0, {(SMP_W-1){1'b1}}});
        push_item(adsr_pkg::MODE_NOTE_ON, '0);
        push_item(adsr_pkg::MODE_TICK, {1'b1, {(SMP_W-1){1'b0}}});
        drive_items(-1);
        settle_block();

        // Directed note walk: attack 0.6/0.5, decay to 0.4, steep release
        reg_plan[adsr_pkg::CFG_ATTACK_COEFF]  = CFG_W'(24'h800000);
        reg_plan[adsr_pkg::CFG_ATTACK_BASE]   = CFG_W'(10066330);
        reg_plan[adsr_pkg::CFG_DECAY_COEFF]   = CFG_W'(24'h800000);
        reg_plan[adsr_pkg::CFG_DECAY_BASE]    = CFG_W'(1677722);
        reg_plan[adsr_pkg::CFG_RELEASE_COEFF] = CFG_W'(24'h800000);
        reg_plan[adsr_pkg::CFG_RELEASE_BASE]  = CFG_W'(-1677722);
        reg_plan[adsr_pkg::CFG_SUSTAIN_LEVEL] = CFG_W'(6710886);
        program_regs();
        push_item(adsr_pkg::MODE_RESET, '1);
        push_item(adsr_pkg::MODE_NOTE_OFF, '0);
        push_item(adsr_pkg::MODE_NOTE_ON, '0);
        push_item(adsr_pkg::MODE_TICK, 24'sd1);
        push_item(adsr_pkg::MODE_TICK, '1);
        push_item(adsr_pkg::MODE_TICK, {1'b0, {(SMP_W-1){1'b1}}});
        push_item(adsr_pkg::MODE_NOTE_ON, '0);
        push_item(adsr_pkg::MODE_TICK, {1'b1, {(SMP_W-1){1'b0}}});
        push_item(adsr_pkg::MODE_TICK, 24'sh5A5A5A);
        push_item(adsr_pkg::MODE_TICK, 24'shA5A5A5);
        push_item(adsr_pkg::MODE_TICK, {1'b0, {(SMP_W-1){1'b1}}});
        push_item(adsr_pkg::MODE_NOTE_ON, '0);
        push_item(adsr_pkg::MODE_NOTE_OFF, '0);
        push_item(adsr_pkg::MODE_NOTE_ON, '0);
        push_item(adsr_pkg::MODE_NOTE_OFF, '0);
        push_item(adsr_pkg::MODE_TICK, {1'b1, {(SMP_W-1){1'b0}}});
        push_item(adsr_pkg::MODE_TICK, '1);
        push_item(adsr_pkg::MODE_TICK, '1);
        push_item(adsr_pkg::MODE_NOTE_OFF, '0);
        drive_items(-1);
        settle_block();

        // Random note phrases under each register profile
        for (int p = 0; p < NUM_PHASES; p++) begin
            fill_profile(PHASE_PLAN[p]);
            program_regs();
            queue_note_phrases(ITEMS_PER_PHASE);
            drive_items((p == 2) ? ITEMS_PER_PHASE / 2 : -1);
            settle_block();
        end

        repeat (32) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
